// ===== hw/rtl/cbpe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic bezier point evaluator package
// default widths, control point register map and pipeline figures
// ----------------------------------------------------------------------------
package cbpe_pkg;

  localparam int COORD_WIDTH_DEF         = 24;
  localparam int PARAM_FRACTION_BITS_DEF = 16;

  localparam int NUM_REGS        = 8;
  localparam int REG_INDEX_WIDTH = $clog2(NUM_REGS);

  localparam logic [REG_INDEX_WIDTH-1:0] REG_START_X          = 3'd0;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_START_Y          = 3'd1;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_FIRST_CONTROL_X  = 3'd2;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_FIRST_CONTROL_Y  = 3'd3;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_SECOND_CONTROL_X = 3'd4;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_SECOND_CONTROL_Y = 3'd5;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_END_X            = 3'd6;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_END_Y            = 3'd7;

  // register stages inside one interpolation unit
  localparam int LERP_STAGES = 3;
  // de casteljau levels for a cubic
  localparam int CURVE_LEVELS = 3;

endpackage

// ===== hw/rtl/cubic_bezier_point_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bezier_point_eval: 2-d cubic bezier curve point evaluator
// evaluates P(t) from four control points in signed integer format
// ----------------------------------------------------------------------------
// One request is taken in every clock cycle: busy is always low, and start
// alone marks a request. Each request gives exactly one result on point_x and
// point_y, marked by done for a single cycle, after one stage for clamping t,
// three levels of de casteljau interpolation of three stages each and one
// stage for rounding. Results come in request order and cannot be held off.
// t above 1.0 is treated as 1.0. Control points are written through
// wr_en/wr_index/wr_data and must only change while no request is in flight.
// ----------------------------------------------------------------------------
module cubic_bezier_point_eval #(
  parameter int COORD_WIDTH         = cbpe_pkg::COORD_WIDTH_DEF,
  parameter int PARAM_FRACTION_BITS = cbpe_pkg::PARAM_FRACTION_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [PARAM_FRACTION_BITS:0]          curve_position,
  output logic                                  done,
  output logic signed [COORD_WIDTH-1:0]         point_x,
  output logic signed [COORD_WIDTH-1:0]         point_y,
  input  logic                                  wr_en,
  input  logic [cbpe_pkg::REG_INDEX_WIDTH-1:0]  wr_index,
  input  logic [COORD_WIDTH-1:0]                wr_data
);

  localparam int CW         = COORD_WIDTH;
  localparam int F          = PARAM_FRACTION_BITS;
  localparam int TW         = F + 1;
  localparam int LS         = cbpe_pkg::LERP_STAGES;
  localparam int PIPE_DEPTH = 1 + LS * cbpe_pkg::CURVE_LEVELS;
  localparam int LATENCY    = PIPE_DEPTH + 1;
  localparam int T_TAPS     = LS * (cbpe_pkg::CURVE_LEVELS - 1) + 1;
  localparam int W3         = CW + 3 * F;

  localparam logic [TW-1:0] T_ONE = TW'(1) << F;

  logic [CW-1:0]        ctrl [cbpe_pkg::NUM_REGS];
  logic signed [CW-1:0] pt [2][4];

  logic [TW-1:0]        t_clamp;
  logic [TW-1:0]        t_line [T_TAPS];
  logic [PIPE_DEPTH-1:0] v_line;
  logic signed [CW-1:0] rounded [2];

  assign busy = 1'b0;

  // control point registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cbpe_pkg::NUM_REGS; i++) begin
        ctrl[i] <= '0;
      end
    end else if (wr_en) begin
      ctrl[wr_index] <= wr_data;
    end
  end

  assign pt[0][0] = $signed(ctrl[cbpe_pkg::REG_START_X]);
  assign pt[1][0] = $signed(ctrl[cbpe_pkg::REG_START_Y]);
  assign pt[0][1] = $signed(ctrl[cbpe_pkg::REG_FIRST_CONTROL_X]);
  assign pt[1][1] = $signed(ctrl[cbpe_pkg::REG_FIRST_CONTROL_Y]);
  assign pt[0][2] = $signed(ctrl[cbpe_pkg::REG_SECOND_CONTROL_X]);
  assign pt[1][2] = $signed(ctrl[cbpe_pkg::REG_SECOND_CONTROL_Y]);
  assign pt[0][3] = $signed(ctrl[cbpe_pkg::REG_END_X]);
  assign pt[1][3] = $signed(ctrl[cbpe_pkg::REG_END_Y]);

  // t saturated to 1.0
  assign t_clamp = (curve_position > T_ONE) ? T_ONE : curve_position;

  always_ff @(posedge clk) begin
    t_line[0] <= t_clamp;
    for (int i = 1; i < T_TAPS; i++) begin
      t_line[i] <= t_line[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_line <= '0;
      done   <= 1'b0;
    end else begin
      v_line <= {v_line[PIPE_DEPTH-2:0], start & ~busy};
      done   <= v_line[PIPE_DEPTH-1];
    end
  end

  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    logic signed [CW+F-1:0]   l1 [3];
    logic signed [CW+2*F-1:0] l2 [2];
    logic signed [W3-1:0]     l3;
    logic signed [W3-1:0]     l3_rnd;

    for (genvar k = 0; k < 3; k++) begin : g_lvl1
      cbpe_lerp #(.IN_WIDTH(CW), .FRAC(F)) u_lerp (
        .clk (clk),
        .a   (pt[ax][k]),
        .b   (pt[ax][k+1]),
        .t   (t_line[0]),
        .r   (l1[k])
      );
    end

    for (genvar k = 0; k < 2; k++) begin : g_lvl2
      cbpe_lerp #(.IN_WIDTH(CW + F), .FRAC(F)) u_lerp (
        .clk (clk),
        .a   (l1[k]),
        .b   (l1[k+1]),
        .t   (t_line[LS]),
        .r   (l2[k])
      );
    end

    cbpe_lerp #(.IN_WIDTH(CW + 2 * F), .FRAC(F)) u_lerp3 (
      .clk (clk),
      .a   (l2[0]),
      .b   (l2[1]),
      .t   (t_line[2*LS]),
      .r   (l3)
    );

    // round to nearest, halves upward
    assign l3_rnd      = l3 + (W3'(1) <<< (3 * F - 1));
    assign rounded[ax] = l3_rnd[3*F+CW-1:3*F];
  end

  always_ff @(posedge clk) begin
    point_x <= rounded[0];
    point_y <= rounded[1];
  end

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result without a matching request");

  a_start_gives_done: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LATENCY done)
    else $error("request lost in the pipeline");

  a_t_saturated: assert property (@(posedge clk) disable iff (rst)
    v_line[0] |-> (t_line[0] <= T_ONE))
    else $error("curve parameter above one inside the pipeline");

endmodule

// ===== hw/rtl/cbpe_lerp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbpe_lerp: exact fixed-point interpolation a*(1-t) + b*t
// three register stages: difference, split partial products, final sum;
// the result carries FRAC more fraction bits than the inputs
// ----------------------------------------------------------------------------
module cbpe_lerp #(
  parameter int IN_WIDTH = cbpe_pkg::COORD_WIDTH_DEF,
  parameter int FRAC     = cbpe_pkg::PARAM_FRACTION_BITS_DEF
) (
  input  logic                         clk,
  input  logic signed [IN_WIDTH-1:0]   a,
  input  logic signed [IN_WIDTH-1:0]   b,
  input  logic        [FRAC:0]         t,
  output logic signed [IN_WIDTH+FRAC-1:0] r
);

  localparam int TW = FRAC + 1;
  localparam int DW = IN_WIDTH + 1;
  localparam int LO = DW / 2;
  localparam int HI = DW - LO;
  localparam int OW = IN_WIDTH + FRAC;

  logic signed [IN_WIDTH-1:0] a1;
  logic signed [DW-1:0]       d1;
  logic        [TW-1:0]       t1;

  logic signed [IN_WIDTH-1:0] a2;
  logic        [LO+TW-1:0]    lo_p;
  logic signed [HI+TW:0]      hi_p;

  logic signed [OW-1:0]       a_term;
  logic signed [OW-1:0]       hi_term;
  logic signed [OW-1:0]       lo_term;

  // stage 1: b - a, so that a*(1-t) + b*t = a + (b - a)*t
  always_ff @(posedge clk) begin
    a1 <= a;
    d1 <= DW'(b) - DW'(a);
    t1 <= t;
  end

  // stage 2: difference split in two halves, each multiplied by t
  always_ff @(posedge clk) begin
    a2   <= a1;
    lo_p <= d1[LO-1:0] * t1;
    hi_p <= $signed(d1[DW-1:LO]) * $signed({1'b0, t1});
  end

  assign a_term  = OW'(a2) <<< FRAC;
  assign hi_term = OW'(hi_p) <<< LO;
  assign lo_term = $signed(OW'(lo_p));

  // stage 3: the exact result fits OW bits, so wrap-around sums are safe
  always_ff @(posedge clk) begin
    r <= a_term + hi_term + lo_term;
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for cubic_bezier_point_eval
// loads sets of control points, sends curve parameters through the start/busy
// request port with random gaps and compares every point_x/point_y result
// against a bit-exact fixed-point bezier evaluation held in the testbench
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CW           = cbpe_pkg::COORD_WIDTH_DEF;
  localparam int FB           = cbpe_pkg::PARAM_FRACTION_BITS_DEF;
  localparam int PW           = FB + 1;
  localparam int PARAM_ONE    = 1 << FB;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 1000;

  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } curve_point_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 start = 1'b0;
  logic                                 busy;
  logic [FB:0]                          curve_position = '0;
  logic                                 done;
  logic signed [CW-1:0]                 point_x;
  logic signed [CW-1:0]                 point_y;
  logic                                 wr_en = 1'b0;
  logic [cbpe_pkg::REG_INDEX_WIDTH-1:0] wr_index = '0;
  logic [CW-1:0]                        wr_data = '0;

  logic signed [CW-1:0] ctrl_pts [cbpe_pkg::NUM_REGS];
  curve_point_t         pending_points [$];
  int unsigned          mismatch_count = 0;
  int unsigned          idle_cycles = 0;

  cubic_bezier_point_eval #(
    .COORD_WIDTH         (CW),
    .PARAM_FRACTION_BITS (FB)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .curve_position (curve_position),
    .done           (done),
    .point_x        (point_x),
    .point_y        (point_y),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // exact bernstein sum, one rounding step, ties toward plus infinity
  function automatic curve_point_t bezier_at(logic [FB:0] pos);
    logic signed [127:0] t, s, w0, w1, w2, w3, ax, ay, half;
    curve_point_t        p;
    t = 128'((pos > PARAM_ONE) ? PARAM_ONE : pos);
    s = PARAM_ONE - t;
    w0 = s * s * s;
    w1 = 3 * s * s * t;
    w2 = 3 * s * t * t;
    w3 = t * t * t;
    half = 128'sd1 <<< (3 * FB - 1);
    ax = w0 * ctrl_pts[cbpe_pkg::REG_START_X]
       + w1 * ctrl_pts[cbpe_pkg::REG_FIRST_CONTROL_X]
       + w2 * ctrl_pts[cbpe_pkg::REG_SECOND_CONTROL_X]
       + w3 * ctrl_pts[cbpe_pkg::REG_END_X] + half;
    ay = w0 * ctrl_pts[cbpe_pkg::REG_START_Y]
       + w1 * ctrl_pts[cbpe_pkg::REG_FIRST_CONTROL_Y]
       + w2 * ctrl_pts[cbpe_pkg::REG_SECOND_CONTROL_Y]
       + w3 * ctrl_pts[cbpe_pkg::REG_END_Y] + half;
    ax = ax >>> (3 * FB);
    ay = ay >>> (3 * FB);
    p.x = ax[CW-1:0];
    p.y = ay[CW-1:0];
    return p;
  endfunction

  // request capture, result check and stall watchdog
  always @(posedge clk) begin
    if (rst) begin
      foreach (ctrl_pts[i]) ctrl_pts[i] = '0;
      pending_points.delete();
      idle_cycles = 0;
    end else begin
      curve_point_t want;
      if (start && !busy) pending_points.push_back(bezier_at(curve_position));
      if (done) begin
        if (pending_points.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d", $time, point_x, point_y);
          mismatch_count++;
        end else begin
          want = pending_points.pop_front();
          if (point_x !== want.x) begin
            $display("%0t: point_x expected %0d, got %0d", $time, want.x, point_x);
            mismatch_count++;
          end
          if (point_y !== want.y) begin
            $display("%0t: point_y expected %0d, got %0d", $time, want.y, point_y);
            mismatch_count++;
          end
        end
      end
      if (wr_en) ctrl_pts[wr_index] = wr_data;
      if ((start && !busy) || done) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [FB:0] pos, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    curve_position <= pos;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cbpe_pkg::REG_INDEX_WIDTH-1:0] idx,
                           input logic signed [CW-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    wr_en    <= 1'b0;
  endtask

  task automatic load_curve(input logic signed [CW-1:0] p0x, p0y, p1x, p1y,
                            input logic signed [CW-1:0] p2x, p2y, p3x, p3y);
    wait_idle();
    write_reg(cbpe_pkg::REG_START_X, p0x);
    write_reg(cbpe_pkg::REG_START_Y, p0y);
    write_reg(cbpe_pkg::REG_FIRST_CONTROL_X, p1x);
    write_reg(cbpe_pkg::REG_FIRST_CONTROL_Y, p1y);
    write_reg(cbpe_pkg::REG_SECOND_CONTROL_X, p2x);
    write_reg(cbpe_pkg::REG_SECOND_CONTROL_Y, p2y);
    write_reg(cbpe_pkg::REG_END_X, p3x);
    write_reg(cbpe_pkg::REG_END_Y, p3y);
  endtask

  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(9, 0))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return '0;
      3, 4:    return CW'($signed($urandom_range(2047, 0)) - 1024);
      default: return CW'($urandom());
    endcase
  endfunction

  function automatic logic [FB:0] rand_position();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 70) return PW'($urandom_range(PARAM_ONE, 0));
    if (r < 85) return PW'($urandom_range((1 << PW) - 1, PARAM_ONE + 1));
    case ($urandom_range(3, 0))
      0:       return '0;
      1:       return PW'(PARAM_ONE);
      2:       return PW'(1);
      default: return PW'(PARAM_ONE - 1);
    endcase
  endfunction

  // control points still at their reset value
  task automatic test_reset_points();
    send_request('0, 0);
    send_request(PW'(PARAM_ONE), 0);
    send_request(PW'(PARAM_ONE / 2), 1);
  endtask

  // t at zero, one, just either side of one and beyond, opposing extremes
  task automatic test_param_extremes();
    logic [FB:0] positions [8];
    positions = '{PW'(0), PW'(1), PW'(PARAM_ONE / 2), PW'(PARAM_ONE - 1),
                  PW'(PARAM_ONE), PW'(PARAM_ONE + 1), PW'((1 << PW) - 1),
                  PW'(PARAM_ONE + PARAM_ONE / 2)};
    load_curve(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
               COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    foreach (positions[i]) send_request(positions[i], i % 2);
  endtask

  // every control point at the top, then at the bottom of the range
  task automatic test_coord_extremes();
    load_curve(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
               COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_request(PW'(PARAM_ONE / 3), 0);
    send_request(rand_position(), 0);
    load_curve(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
               COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    send_request(PW'(PARAM_ONE / 3), 0);
    send_request(rand_position(), 2);
  endtask

  // exact halves, positive and negative
  task automatic test_rounding_ties();
    load_curve(CW'(4), CW'(-4), '0, '0, '0, '0, '0, '0);
    send_request(PW'(PARAM_ONE / 2), 0);
    load_curve(CW'(12), CW'(-12), '0, '0, '0, '0, '0, '0);
    send_request(PW'(PARAM_ONE / 2), 0);
    load_curve('0, '0, CW'(4), CW'(-4), '0, '0, '0, '0);
    send_request(PW'(PARAM_ONE / 2), 0);
    load_curve('0, '0, '0, '0, CW'(-4), CW'(4), '0, '0);
    send_request(PW'(PARAM_ONE / 2), 0);
  endtask

  // random curves, random t, random gaps, occasional full drain
  task automatic test_random_curves();
    for (int phase = 0; phase < 6; phase++) begin
      load_curve(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord(), rand_coord());
      for (int n = 0; n < 70; n++) begin
        if ($urandom_range(39, 0) == 0) wait_idle();
        send_request(rand_position(), rand_gap());
      end
    end
  endtask

  // one request every cycle
  task automatic test_back_to_back();
    load_curve(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
               rand_coord(), rand_coord(), rand_coord(), rand_coord());
    for (int n = 0; n < 40; n++) send_request(rand_position(), 0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_points();
    test_param_extremes();
    test_coord_extremes();
    test_rounding_ties();
    test_random_curves();
    test_back_to_back();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/cbpe_pkg.sv
hw/rtl/cbpe_lerp.sv
hw/rtl/cubic_bezier_point_eval.sv
tb/sv/tb_top.sv
